### src/cqf_pkg.sv
`default_nettype none

package cqf_pkg;

  // fixed field widths
  localparam int unsigned WordW   = 32;
  localparam int unsigned ActionW = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned KindW   = 3;
  localparam int unsigned CapW    = 5;

  localparam int unsigned DepthDefault = 16;
  localparam logic [CapW-1:0] CapReset = CapW'(16);

  typedef enum logic [ActionW-1:0] {
    ACT_ENQ  = 2'd0,
    ACT_DEQ  = 2'd1,
    ACT_SHOW = 2'd2
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [KindW-1:0] {
    KIND_DEQ    = 3'd0,
    KIND_HEAD   = 3'd1,
    KIND_ITEM   = 3'd2,
    KIND_TAIL   = 3'd3,
    KIND_STATUS = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEQ,
    S_FULL,
    S_EMPTY,
    S_DHEAD,
    S_DITEM,
    S_DTAIL
  } state_e;

endpackage

`default_nettype wire

### src/circular_queue_fifo.sv
`default_nettype none

// Ring-buffer queue of 32-bit words held in one single-port-read synchronous memory of DEPTH
// entries, of which capacity_in_use slots (clamped to 1..DEPTH) form the ring. Each request on
// the slave stream is an enqueue, a dequeue or a display, chosen by s_axis_tuser. A successful
// enqueue gives no reply; a dequeue first reads the memory into a registered read output and
// then loads its reply from it; a full or empty reply is loaded from a state of its own. A
// display sends one result per cycle while the reply register is free, paced by the single
// memory read port, with the head index first, then the words from head to tail, then the tail
// index marked by tlast. One request is worked on at a time; the reply register lets the next
// request in while the last reply still waits for m_axis_tready. The storage needs no clearing
// after reset. Write the capacity only while the queue is idle.
module circular_queue_fifo #(
  parameter int unsigned DEPTH = cqf_pkg::DepthDefault
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  // capacity register
  input  wire                         cfg_we_i,
  input  wire  [cqf_pkg::CapW-1:0]    cfg_wdata_i,
  // request stream
  input  wire                         s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire  [cqf_pkg::WordW-1:0]   s_axis_tdata,   // [31:0] value
  input  wire  [cqf_pkg::ActionW-1:0] s_axis_tuser,   // [1:0] action
  // reply stream
  output logic                        m_axis_tvalid,
  input  wire                         m_axis_tready,
  output logic [cqf_pkg::WordW-1:0]   m_axis_tdata,   // [31:0] result_value
  output logic [cqf_pkg::StatusW+cqf_pkg::KindW-1:0] m_axis_tuser, // [1:0] status, [4:2] kind
  output logic                        m_axis_tlast    // last reply of the request
);

  import cqf_pkg::*;

  // ring index width and a width that holds counts up to DEPTH
  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned ExtW = (CntW > CapW) ? CntW : CapW;

  // control state
  state_e              state_q, state_d;
  logic [CapW-1:0]     cap_q;
  logic [IdxW-1:0]     head_q, head_d;
  logic [IdxW-1:0]     tail_q, tail_d;
  logic                empty_q, empty_d;
  logic [IdxW-1:0]     idx_q, idx_d;       // display walk position
  logic [CntW-1:0]     listed_q, listed_d; // words listed so far

  // storage
  logic [WordW-1:0]    mem_q [DEPTH];
  logic [WordW-1:0]    rd_data_q;
  logic                wr_en, rd_en;
  logic [IdxW-1:0]     wr_addr, rd_addr;

  // reply register
  logic                out_valid_q;
  status_e             out_status_q, out_status_d;
  kind_e               out_kind_q, out_kind_d;
  logic [WordW-1:0]    out_value_q, out_value_d;
  logic                out_last_q, out_last_d;
  logic                out_load;
  logic                out_free;

  logic [ExtW-1:0]     eff_cap;
  logic [IdxW-1:0]     tail_adv, idx_adv;
  logic [CntW-1:0]     listed_inc;
  action_e             action;

  // capacity clamped to 1..DEPTH
  always_comb begin
    eff_cap = ExtW'(cap_q);
    if (eff_cap == '0) begin
      eff_cap = ExtW'(1);
    end else if (eff_cap > ExtW'(DEPTH)) begin
      eff_cap = ExtW'(DEPTH);
    end
  end

  // next ring index, wrapping at the capacity
  function automatic logic [IdxW-1:0] adv(input logic [IdxW-1:0] i, input logic [ExtW-1:0] cap);
    logic [ExtW-1:0] n;
    n = ExtW'(i) + ExtW'(1);
    return (n >= cap) ? '0 : n[IdxW-1:0];
  endfunction

  assign tail_adv   = adv(tail_q, eff_cap);
  assign idx_adv    = adv(idx_q, eff_cap);
  assign listed_inc = listed_q + CntW'(1);
  assign action     = action_e'(s_axis_tuser);
  assign out_free   = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      empty_q  <= 1'b1;
      idx_q    <= '0;
      listed_q <= '0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      empty_q  <= empty_d;
      idx_q    <= idx_d;
      listed_q <= listed_d;
    end
  end

  // next state, memory accesses and reply loading
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    empty_d      = empty_q;
    idx_d        = idx_q;
    listed_d     = listed_q;
    wr_en        = 1'b0;
    wr_addr      = tail_adv;
    rd_en        = 1'b0;
    rd_addr      = head_q;
    out_load     = 1'b0;
    out_status_d = ST_OK;
    out_kind_d   = KIND_STATUS;
    out_value_d  = '0;
    out_last_d   = 1'b1;
    s_axis_tready = (state_q == S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          unique case (action)
            ACT_ENQ: begin
              if (empty_q) begin
                // first word always lands in slot zero
                wr_en   = 1'b1;
                wr_addr = '0;
                head_d  = '0;
                tail_d  = '0;
                empty_d = 1'b0;
              end else if (tail_adv == head_q) begin
                state_d = S_FULL;
              end else begin
                wr_en  = 1'b1;
                tail_d = tail_adv;
              end
            end
            ACT_DEQ: begin
              if (empty_q) begin
                state_d = S_EMPTY;
              end else begin
                rd_en   = 1'b1;
                state_d = S_DEQ;
              end
            end
            ACT_SHOW: begin
              if (empty_q) begin
                state_d = S_EMPTY;
              end else begin
                rd_en    = 1'b1;
                idx_d    = head_q;
                listed_d = '0;
                state_d  = S_DHEAD;
              end
            end
            default: ; // unused code, dropped
          endcase
        end
      end
      S_DEQ: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_kind_d  = KIND_DEQ;
          out_value_d = rd_data_q;
          if (head_q == tail_q) begin
            head_d  = '0;
            tail_d  = '0;
            empty_d = 1'b1;
          end else begin
            head_d = adv(head_q, eff_cap);
          end
          state_d = S_IDLE;
        end
      end
      S_FULL: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = ST_FULL;
          state_d      = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = ST_EMPTY;
          state_d      = S_IDLE;
        end
      end
      S_DHEAD: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_kind_d  = KIND_HEAD;
          out_value_d = WordW'(head_q);
          out_last_d  = 1'b0;
          state_d     = S_DITEM;
        end
      end
      S_DITEM: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_kind_d  = KIND_ITEM;
          out_value_d = rd_data_q;
          out_last_d  = 1'b0;
          // stop one past the tail, or after a full lap
          if (idx_adv != tail_adv && listed_inc < CntW'(DEPTH)) begin
            rd_en    = 1'b1;
            rd_addr  = idx_adv;
            idx_d    = idx_adv;
            listed_d = listed_inc;
          end else begin
            state_d = S_DTAIL;
          end
        end
      end
      S_DTAIL: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_kind_d  = KIND_TAIL;
          out_value_d = WordW'(tail_q);
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // word storage, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= s_axis_tdata;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // reply register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_kind_q   <= out_kind_d;
      out_value_q  <= out_value_d;
      out_last_q   <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = {out_kind_q, out_status_q};
  assign m_axis_tlast  = out_last_q;

  // an empty queue sits at index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q |-> (head_q == '0 && tail_q == '0))
    else $error("empty queue with nonzero indices");

  // indices never leave the storage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ExtW'(head_q) < ExtW'(DEPTH)) && (ExtW'(tail_q) < ExtW'(DEPTH))
      && (ExtW'(idx_q) < ExtW'(DEPTH)))
    else $error("ring index beyond depth");

  // only head index and listed words are unmarked replies
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |->
      (out_kind_q == KIND_HEAD || out_kind_q == KIND_ITEM))
    else $error("unmarked reply of wrong kind");

  // a dequeue on a filled queue goes on to read the memory
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && action == ACT_DEQ && !empty_q) |=> (state_q == S_DEQ))
    else $error("dequeue did not start");

  // the display walk never lists more than the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    listed_q < CntW'(DEPTH))
    else $error("display walk overran");

endmodule

`default_nettype wire
